// ----- rtl/core/iirtdf2_pkg.sv -----
// Shared types, constants and register codes of the transposed direct form II IIR filter.
package iirtdf2_pkg;

  localparam int MAX_ORDER_DEF = 6;
  localparam int CHANNELS_DEF  = 2;

  localparam int SAMPLE_BITS = 24;
  localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int USER_BITS   = 2;
  localparam int STATE_BITS  = SAMPLE_BITS + 16;
  localparam int COEF_BITS   = 32;
  localparam int PAIR_BITS   = 2 * COEF_BITS;
  localparam int ACC_BITS    = 32;
  localparam int PROD_BITS   = COEF_BITS + ACC_BITS;
  localparam int ORDER_BITS  = 3;
  localparam int PROD_SHIFT  = 20;
  localparam int OUT_SHIFT   = 8;

  localparam int REG_ORDER     = 0;
  localparam int REG_COEF_BASE = 1;

  localparam logic [PAIR_BITS-1:0] COEF0_RESET = 64'h0000_0000_1000_0000;

  typedef enum logic {
    ACT_FILTER = 1'b0,
    ACT_SET    = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD0,
    ST_OUT0,
    ST_MULB,
    ST_MULA,
    ST_LAST
  } iir_state_t;

endpackage

// ----- rtl/core/iirtdf2_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
module iirtdf2_ram
  import iirtdf2_pkg::*;
#(
  parameter int WIDTH = STATE_BITS,
  parameter int DEPTH = MAX_ORDER_DEF * CHANNELS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/iir_transposed_df2_filter.sv -----
// Top level of the multi-channel transposed direct form II IIR filter.
//
//  channel   | direction | tdata              | tuser                   | tlast
//  s_axis    | in        | sample_in          | action, channel         | block_end
//  m_axis    | out       | sample_out         | channel_out             | block_end_out
//  cfg       | in        | cfg_we, cfg_index, cfg_data: filter_order, coef_pair_0..6
//
// A filter request of order N keeps the block busy until its result is loaded: one
// shared 32x32 multiplier produces one product a cycle, 2N+1 products in all, and the
// state words pass through a single-port-pair RAM. A set request, or a request for a
// channel that does not exist, is taken without leaving the idle state.
// Reset and order writes clear the state at once through per-word valid bits; there is
// no clearing pass. The last step holds while the output register is still full.
module iir_transposed_df2_filter
  import iirtdf2_pkg::*;
#(
  parameter int MAX_ORDER = MAX_ORDER_DEF,
  parameter int CHANNELS  = CHANNELS_DEF,
  localparam int COEF_REGS = MAX_ORDER + 1,
  localparam int CFG_IDX_W = $clog2(COEF_REGS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PAIR_BITS-1:0]  cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TDATA_BITS-1:0] s_axis_tdata,   // sample_in
  input  logic [USER_BITS-1:0]  s_axis_tuser,   // action, channel
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [TDATA_BITS-1:0] m_axis_tdata,   // sample_out
  output logic [0:0]            m_axis_tuser,   // channel_out
  output logic                  m_axis_tlast
);

  localparam int DEPTH   = CHANNELS * MAX_ORDER;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int K_W     = $clog2(2 * MAX_ORDER + 1);
  localparam int PAIR_W  = K_W - 1;
  localparam int CNT_W   = ORDER_BITS + 1;
  localparam int RND_W   = PROD_BITS - PROD_SHIFT;
  localparam int TB_W    = COEF_BITS + SAMPLE_BITS - PROD_SHIFT;
  localparam int T_W     = RND_W + 2;

  localparam logic signed [PROD_BITS-1:0] HALF_P = PROD_BITS'(1) << (PROD_SHIFT - 1);
  localparam logic signed [T_W-1:0]       HALF_Y = T_W'(1) << (OUT_SHIFT - 1);

  localparam logic signed [T_W-1:0] ACC_MAX = {{(T_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [T_W-1:0] ACC_MIN = {{(T_W-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [T_W-1:0] ST_MAX =
    {{(T_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [T_W-1:0] ST_MIN =
    {{(T_W-STATE_BITS+1){1'b1}}, {(STATE_BITS-1){1'b0}}};
  localparam logic signed [ACC_BITS-1:0] SMP_MAX =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] SMP_MIN =
    {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [T_W-1:0] v);
    if (v > ACC_MAX) begin
      return ACC_MAX[ACC_BITS-1:0];
    end else if (v < ACC_MIN) begin
      return ACC_MIN[ACC_BITS-1:0];
    end
    return v[ACC_BITS-1:0];
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [T_W-1:0] v);
    if (v > ST_MAX) begin
      return ST_MAX[STATE_BITS-1:0];
    end else if (v < ST_MIN) begin
      return ST_MIN[STATE_BITS-1:0];
    end
    return v[STATE_BITS-1:0];
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat_smp(input logic signed [ACC_BITS-1:0] v);
    if (v > SMP_MAX) begin
      return SMP_MAX[SAMPLE_BITS-1:0];
    end else if (v < SMP_MIN) begin
      return SMP_MIN[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

  iir_state_t state, state_next;

  logic [ORDER_BITS-1:0] order;
  logic [ORDER_BITS-1:0] order_wr;
  logic [PAIR_BITS-1:0]  coef_pair [COEF_REGS];
  logic [CFG_IDX_W-1:0]  pair_wr;

  logic                          accept;
  logic                          in_ch;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          ch_ok;
  logic signed [STATE_BITS-1:0]  set_value;

  logic signed [SAMPLE_BITS-1:0] x;
  logic                          ch;
  logic                          blk_end;
  logic [CNT_W-1:0]              j;
  logic [ADDR_W-1:0]             base;

  logic                          rd_en;
  logic [CNT_W-1:0]              rd_off;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          wr_en;
  logic [CNT_W-1:0]              wr_off;
  logic [ADDR_W-1:0]             wr_addr;
  logic [K_W-1:0]                coef_k;
  logic                          mul_y;
  logic                          add_term;
  logic                          ld_out;
  logic                          out_free;

  logic [PAIR_W-1:0]             pair_sel;
  logic signed [COEF_BITS-1:0]   coef_w;
  logic signed [ACC_BITS-1:0]    opnd;
  logic signed [PROD_BITS-1:0]   mul_res;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [PROD_BITS-1:0]   prod_sum;
  logic signed [PROD_BITS-1:0]   prod_shr;
  logic signed [RND_W-1:0]       prod_rnd;

  logic [DEPTH-1:0]              valid;
  logic signed [STATE_BITS-1:0]  fill;
  logic                          rd_vld;
  logic [STATE_BITS-1:0]         ram_q;
  logic signed [STATE_BITS-1:0]  s_rd;

  logic signed [T_W-1:0]         yacc;
  logic signed [T_W-1:0]         yacc_shr;
  logic signed [ACC_BITS-1:0]    y;
  logic signed [TB_W-1:0]        tb;
  logic signed [STATE_BITS-1:0]  sreg;
  logic signed [T_W-1:0]         t_sum;
  logic signed [STATE_BITS-1:0]  wr_data;

  logic                          out_valid;
  logic [SAMPLE_BITS-1:0]        out_data;
  logic                          out_ch;
  logic                          out_last;

  // Request decode
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign in_ch     = s_axis_tuser[1];
  assign in_sample = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
  assign ch_ok     = (32'(in_ch) < CHANNELS);
  assign set_value = STATE_BITS'(in_sample) <<< OUT_SHIFT;
  assign out_free  = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  // Configuration decode
  always_comb begin
    order_wr = cfg_data[ORDER_BITS-1:0];
    if (order_wr == '0) begin
      order_wr = ORDER_BITS'(1);
    end else if (32'(order_wr) > MAX_ORDER) begin
      order_wr = ORDER_BITS'(MAX_ORDER);
    end
  end

  assign pair_wr = cfg_index - CFG_IDX_W'(REG_COEF_BASE);

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && s_axis_tuser[0] == ACT_FILTER && ch_ok) begin
          state_next = ST_PROD0;
        end
      end
      ST_PROD0: state_next = ST_OUT0;
      ST_OUT0:  state_next = ST_MULB;
      ST_MULB:  state_next = ST_MULA;
      ST_MULA: begin
        if (j == CNT_W'(order) - CNT_W'(1)) begin
          state_next = ST_LAST;
        end else begin
          state_next = ST_MULB;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    rd_en    = 1'b0;
    rd_off   = '0;
    wr_en    = 1'b0;
    wr_off   = '0;
    coef_k   = '0;
    mul_y    = 1'b0;
    add_term = 1'b0;
    ld_out   = 1'b0;
    case (state)
      ST_PROD0: begin
        rd_en = 1'b1;
      end
      ST_OUT0: begin
        rd_en  = (order > ORDER_BITS'(1));
        rd_off = CNT_W'(1);
      end
      ST_MULB: begin
        coef_k   = K_W'(j + CNT_W'(1));
        wr_en    = (j != '0);
        wr_off   = j - CNT_W'(1);
        add_term = 1'b1;
      end
      ST_MULA: begin
        coef_k = K_W'({1'b0, j} + (CNT_W + 1)'(order) + (CNT_W + 1)'(1));
        mul_y  = 1'b1;
        rd_en  = (j + CNT_W'(2) < CNT_W'(order));
        rd_off = j + CNT_W'(2);
      end
      ST_LAST: begin
        wr_en  = 1'b1;
        wr_off = CNT_W'(order) - CNT_W'(1);
        ld_out = out_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Shared multiplier and rounding to state precision
  assign pair_sel = coef_k[K_W-1:1];
  assign coef_w   = coef_k[0] ? $signed(coef_pair[pair_sel][PAIR_BITS-1:COEF_BITS])
                              : $signed(coef_pair[pair_sel][COEF_BITS-1:0]);
  assign opnd     = mul_y ? y : ACC_BITS'(x);
  assign mul_res  = PROD_BITS'(coef_w) * PROD_BITS'(opnd);
  assign prod_sum = prod + HALF_P;
  assign prod_shr = prod_sum >>> PROD_SHIFT;
  assign prod_rnd = prod_shr[RND_W-1:0];

  // State words: a word not written since the last clear reads as the fill value
  assign base    = ch ? ADDR_W'(MAX_ORDER) : '0;
  assign rd_addr = base + ADDR_W'(rd_off);
  assign wr_addr = base + ADDR_W'(wr_off);
  assign s_rd    = rd_vld ? $signed(ram_q) : fill;

  assign yacc     = T_W'(prod_rnd) + T_W'(s_rd);
  assign yacc_shr = (yacc + HALF_Y) >>> OUT_SHIFT;

  assign t_sum   = T_W'(tb) - T_W'(prod_rnd) + (add_term ? T_W'(sreg) : T_W'(0));
  assign wr_data = sat_state(t_sum);

  iirtdf2_ram #(
    .WIDTH (STATE_BITS),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      order     <= ORDER_BITS'(1);
      valid     <= '0;
      fill      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < COEF_REGS; i++) begin
        coef_pair[i] <= (i == 0) ? COEF0_RESET : '0;
      end
    end else begin
      state <= state_next;
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (accept && s_axis_tuser[0] == ACT_SET) begin
        valid <= '0;
        fill  <= set_value;
      end
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_W'(REG_ORDER)) begin
          order <= order_wr;
          valid <= '0;
          fill  <= '0;
        end else if (32'(pair_wr) < COEF_REGS) begin
          coef_pair[pair_wr[PAIR_W-1:0]] <= cfg_data;
        end
      end
      if (ld_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state != ST_LAST) begin
      prod <= mul_res;
    end
    if (accept) begin
      x       <= in_sample;
      ch      <= in_ch;
      blk_end <= s_axis_tlast;
    end
    if (rd_en) begin
      rd_vld <= valid[rd_addr];
    end
    if (state == ST_OUT0) begin
      y <= sat_acc(yacc_shr);
      j <= '0;
    end
    if (state == ST_MULB) begin
      sreg <= s_rd;
    end
    if (state == ST_MULA) begin
      tb <= prod_rnd[TB_W-1:0];
      j  <= j + CNT_W'(1);
    end
    if (ld_out) begin
      out_data <= sat_smp(y);
      out_ch   <= ch;
      out_last <= blk_end;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_BITS'(out_data);
  assign m_axis_tuser  = out_ch;
  assign m_axis_tlast  = out_last;

endmodule

// ----- rtl/core/iirtdf2_checker.sv -----
// Port-level assertions for the IIR filter, bound to its top level.
module iirtdf2_checker
  import iirtdf2_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [USER_BITS-1:0]  s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [TDATA_BITS-1:0] m_axis_tdata,
  input logic [0:0]            m_axis_tuser,
  input logic                  m_axis_tlast
);

  // A stalled result must hold still.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("Stalled result changed");

  // A filter request on channel 0 keeps the block busy on the following cycle.
  a_busy_after_filter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == ACT_FILTER &&
      s_axis_tuser[1] == 1'b0 |=> !s_axis_tready)
    else $error("Filter request did not occupy the block");

  // A new result is only loaded at the end of a request's processing.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("Result appeared while the block was idle");

  // The block only becomes busy by accepting a request.
  a_busy_needs_request: assert property (@(posedge clk) disable iff (rst)
    $fell(s_axis_tready) |-> $past(s_axis_tvalid))
    else $error("Input ready dropped without a request");

endmodule

bind iir_transposed_df2_filter iirtdf2_checker u_iirtdf2_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- bench/iir_transposed_df2_filter_tb.sv -----
// Self-checking testbench for the transposed direct form II IIR filter with a built-in predictor.
module iir_transposed_df2_filter_tb
  import iirtdf2_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COEF_REGS   = MAX_ORDER_DEF + 1;
  localparam int CFG_IDX_W   = $clog2(COEF_REGS + 1);
  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE_GAP  = 24;
  localparam int COEF_MILD   = 0;
  localparam int COEF_WIDE   = 1;
  localparam int COEF_CORNER = 2;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   channel;
    logic                   last;
  } filter_result_t;

  class filter_scoreboard;
    logic [PAIR_BITS-1:0] coef_regs[COEF_REGS];
    longint               state_words[CHANNELS_DEF][MAX_ORDER_DEF];
    int                   order;
    filter_result_t       expected_q[$];
    int                   errors;
    int                   filtered;
    int                   presets;

    function new();
      foreach (coef_regs[i]) coef_regs[i] = '0;
      coef_regs[0] = COEF0_RESET;
      order = 1;
      errors = 0;
      filtered = 0;
      presets = 0;
      clear_state();
    endfunction

    function void clear_state();
      foreach (state_words[c, j]) state_words[c][j] = 0;
    endfunction

    function void write_reg(int idx, logic [PAIR_BITS-1:0] data);
      if (idx == REG_ORDER) begin
        order = int'(data[ORDER_BITS-1:0]);
        if (order < 1) order = 1;
        if (order > MAX_ORDER_DEF) order = MAX_ORDER_DEF;
        clear_state();
      end else if (idx >= REG_COEF_BASE && idx < REG_COEF_BASE + COEF_REGS) begin
        coef_regs[idx - REG_COEF_BASE] = data;
      end
    endfunction

    function longint coefficient(int k);
      int word;
      if (k / 2 >= COEF_REGS) return 0;
      word = (k % 2) ? coef_regs[k / 2][63:32] : coef_regs[k / 2][31:0];
      return longint'(word);
    endfunction

    function longint round_shift(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function longint saturate(longint v, int w);
      longint hi;
      hi = (longint'(1) << (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(action_t act, logic ch, logic [SAMPLE_BITS-1:0] smp, logic last);
      longint         x;
      longint         y;
      longint         t;
      longint         clipped;
      filter_result_t r;
      x = longint'($signed(smp));
      if (act == ACT_SET) begin
        foreach (state_words[c, j]) state_words[c][j] = saturate(x * 256, STATE_BITS);
        presets++;
        return;
      end
      y = round_shift(coefficient(0) * x, PROD_SHIFT) + state_words[ch][0];
      y = saturate(round_shift(y, OUT_SHIFT), ACC_BITS);
      for (int j = 0; j < order; j++) begin
        t = round_shift(coefficient(j + 1) * x, PROD_SHIFT)
          - round_shift(coefficient(order + j + 1) * y, PROD_SHIFT);
        if (j + 1 < order) t += state_words[ch][j + 1];
        state_words[ch][j] = saturate(t, STATE_BITS);
      end
      clipped = saturate(y, SAMPLE_BITS);
      r.sample = clipped[SAMPLE_BITS-1:0];
      r.channel = ch;
      r.last = last;
      expected_q.push_back(r);
      filtered++;
    endfunction

    function void check_response(logic [SAMPLE_BITS-1:0] smp, logic ch, logic last);
      filter_result_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: sample_out %0d channel_out %0d", $signed(smp), ch);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (smp !== e.sample) begin
        $error("sample_out: expected %0d, got %0d", $signed(e.sample), $signed(smp));
        errors++;
      end
      if (ch !== e.channel) begin
        $error("channel_out: expected %0d, got %0d", e.channel, ch);
        errors++;
      end
      if (last !== e.last) begin
        $error("block_end_out: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [PAIR_BITS-1:0]  cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_BITS-1:0] s_axis_tdata;   // sample_in
  logic [USER_BITS-1:0]  s_axis_tuser;   // action, channel
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_BITS-1:0] m_axis_tdata;   // sample_out
  logic [0:0]            m_axis_tuser;   // channel_out
  logic                  m_axis_tlast;

  filter_scoreboard sb;
  bit               sender_burst;
  bit               receiver_burst;
  int               idle_cycles;
  int               settings;

  iir_transposed_df2_filter uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_response(m_axis_tdata[SAMPLE_BITS-1:0], m_axis_tuser[0], m_axis_tlast);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_request(action_t'(s_axis_tuser[0]), s_axis_tuser[1],
                        s_axis_tdata[SAMPLE_BITS-1:0], s_axis_tlast);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Timed out after %0d cycles with no request moving.", IDLE_LIMIT);
        $display("FAIL iir_transposed_df2_filter");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = receiver_burst ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return '0;
      3: return '1;
      4, 5: begin
        v = $urandom_range(0, 8191);
        v = v - 4096;
        return v[SAMPLE_BITS-1:0];
      end
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [PAIR_BITS-1:0] pick_pair(int style);
    int lo;
    int hi;
    case (style)
      COEF_MILD: begin
        lo = $urandom_range(0, 1 << 26);
        hi = $urandom_range(0, 1 << 26);
        return {hi - (1 << 25), lo - (1 << 25)};
      end
      COEF_CORNER: begin
        case ($urandom_range(0, 3))
          0: return 64'h7FFF_FFFF_8000_0000;
          1: return 64'h8000_0000_7FFF_FFFF;
          2: return '1;
          default: return '0;
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_request(input action_t act, input logic ch,
                              input logic [SAMPLE_BITS-1:0] smp, input logic last);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= {ch, act};
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain(input bit settle);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    if (settle) repeat (SETTLE_GAP) @(posedge clk);
    else @(posedge clk);
  endtask

  task automatic load_settings(input logic [ORDER_BITS-1:0] order_code, input int style);
    logic [PAIR_BITS-1:0] data;
    drain(1'b1);
    sender_burst   = ($urandom_range(0, 3) == 0);
    receiver_burst = ($urandom_range(0, 3) == 0);
    cfg_we <= 1'b1;
    for (int i = 0; i <= COEF_REGS; i++) begin
      if (i == REG_ORDER) begin
        data = {$urandom, $urandom};
        data[ORDER_BITS-1:0] = order_code;
      end else begin
        data = pick_pair(style);
      end
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= data;
      sb.write_reg(i, data);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 || $urandom_range(0, 49) == 0) drain(1'b0);
      send_request(($urandom_range(0, 15) == 0) ? ACT_SET : ACT_FILTER,
                   1'($urandom), pick_sample(), 1'($urandom));
    end
  endtask

  initial begin
    sb = new();
    settings = 1;
    sender_burst = 1'b0;
    receiver_burst = 1'b0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(ACT_FILTER, 1'b0, 24'h000000, 1'b0);
    send_request(ACT_FILTER, 1'b1, 24'h7FFFFF, 1'b1);
    send_request(ACT_FILTER, 1'b0, 24'h800000, 1'b0);
    send_request(ACT_FILTER, 1'b1, 24'hFFFFFF, 1'b1);
    send_request(ACT_FILTER, 1'b0, 24'h000001, 1'b0);
    send_request(ACT_SET,    1'b1, 24'h7FFFFF, 1'b1);
    send_request(ACT_FILTER, 1'b0, 24'h7FFFFF, 1'b0);
    send_request(ACT_FILTER, 1'b1, 24'h800000, 1'b0);
    send_request(ACT_SET,    1'b0, 24'h800000, 1'b0);
    send_request(ACT_FILTER, 1'b1, 24'h800000, 1'b1);
    send_request(ACT_FILTER, 1'b0, 24'h000000, 1'b0);
    send_request(ACT_SET,    1'b0, 24'h000000, 1'b1);
    send_request(ACT_FILTER, 1'b0, 24'h123456, 1'b0);
    send_request(ACT_FILTER, 1'b1, 24'hABCDEF, 1'b1);

    load_settings(3'd6, COEF_MILD);
    sender_burst   = 1'b1;
    receiver_burst = 1'b1;
    run_random(70);
    load_settings(3'd7, COEF_CORNER);
    run_random(50);
    load_settings(3'd0, COEF_WIDE);
    run_random(50);
    for (int p = 0; p < 7; p++) begin
      load_settings(ORDER_BITS'($urandom_range(0, 7)), (p % 3 == 0) ? COEF_WIDE : COEF_MILD);
      run_random(52);
    end

    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (40) @(posedge clk);
    $display("Covered %0d filtered samples and %0d state presets over %0d filter settings,",
             sb.filtered, sb.presets, settings);
    $display("including orders out of range, coefficient corners and saturating outputs.");
    if (sb.errors == 0) begin
      $display("PASS iir_transposed_df2_filter");
    end else begin
      $display("FAIL iir_transposed_df2_filter");
    end
    $finish;
  end

endmodule
